>>> rtl/quaternion_key_decode_validate_unit_defines.svh
// Assertion macros shared by the quaternion key decode and validate RTL.
`ifndef QUATERNION_KEY_DECODE_VALIDATE_UNIT_DEFINES_SVH
`define QUATERNION_KEY_DECODE_VALIDATE_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define QKDV_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define QKDV_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/qkdv_pkg.sv
// Types, constants and the microcode program of the quaternion key decoder.
`default_nettype none

package qkdv_pkg;

  // Track store geometry.
  localparam int TRACKS = 256;
  localparam int SLOT_W = $clog2(TRACKS);
  localparam int ROT_W  = 64;

  // Small-component decode: magnitude * 23170 (0.7071 in Q1.15), rounded.
  localparam logic [14:0] DEC_SCALE = 15'd23170;
  localparam logic [14:0] DEC_ROUND = 15'd16383;
  localparam logic [14:0] DEC_DIV   = 15'd32767;

  // Limits with 30 fraction bits (Q1.30 for ONE_Q30 and SUM_LIMIT); BIG_SLACK and Q15_MAX in Q1.15.
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [30:0] SUM_LIMIT = 31'd805413742;
  localparam logic [15:0] BIG_SLACK = 16'd3;
  localparam logic signed [33:0] DOT_LIMIT = -34'sd214748;
  localparam logic [14:0] Q15_MAX   = 15'h7fff;

  // Half-float exponent field that marks infinity or NaN.
  localparam logic [4:0] HALF_EXP_ONES = 5'h1f;

  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_SUM  = 3'd1,
    ST_BIG  = 3'd2,
    ST_FLIP = 3'd3,
    ST_NAN  = 3'd4
  } status_t;

  // Datapath operations, one per microcode step.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_MUL,
    OP_DIV,
    OP_SQR,
    OP_CHKSUM,
    OP_SQRT,
    OP_BIG,
    OP_CHKBIG,
    OP_DOTMUL,
    OP_DOTACC,
    OP_CHKDOT,
    OP_HALF,
    OP_FINISH
  } op_t;

  // Jump conditions of the sequencer.
  typedef enum logic [2:0] {
    JC_NONE,
    JC_ALWAYS,
    JC_CNT2,
    JC_CNT3,
    JC_SQRT,
    JC_FAIL,
    JC_FAIL_FIRST
  } jc_t;

  localparam int UPC_W = 4;

  // Program addresses.
  localparam logic [UPC_W-1:0] UA_MUL     = 4'd0;
  localparam logic [UPC_W-1:0] UA_SQRT    = 4'd4;
  localparam logic [UPC_W-1:0] UA_DOTMUL  = 4'd7;
  localparam logic [UPC_W-1:0] UA_HALF    = 4'd10;
  localparam logic [UPC_W-1:0] UA_FINISH  = 4'd11;
  localparam logic [UPC_W-1:0] ENTRY_ROT  = UA_MUL;
  localparam logic [UPC_W-1:0] ENTRY_HALF = UA_HALF;

  typedef struct packed {
    op_t              op;
    jc_t              jc;
    logic [UPC_W-1:0] target;
  } ucode_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic start;
    logic rot;
    op_t  op;
  } ctrl_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic       fail;
    logic       first;
    logic [1:0] cnt;
    logic       sqrt_last;
  } flags_t;

  // Microcode program: the rotation path starts at address 0, the
  // half-float path at UA_HALF; both end in UA_FINISH.
  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
    ucode_t w;
    unique case (addr)
      4'd0:    w = '{op: OP_MUL,    jc: JC_NONE,       target: UA_MUL};
      4'd1:    w = '{op: OP_DIV,    jc: JC_NONE,       target: UA_MUL};
      4'd2:    w = '{op: OP_SQR,    jc: JC_CNT2,       target: UA_MUL};
      4'd3:    w = '{op: OP_CHKSUM, jc: JC_FAIL,       target: UA_FINISH};
      4'd4:    w = '{op: OP_SQRT,   jc: JC_SQRT,       target: UA_SQRT};
      4'd5:    w = '{op: OP_BIG,    jc: JC_NONE,       target: UA_MUL};
      4'd6:    w = '{op: OP_CHKBIG, jc: JC_FAIL_FIRST, target: UA_FINISH};
      4'd7:    w = '{op: OP_DOTMUL, jc: JC_NONE,       target: UA_MUL};
      4'd8:    w = '{op: OP_DOTACC, jc: JC_CNT3,       target: UA_DOTMUL};
      4'd9:    w = '{op: OP_CHKDOT, jc: JC_ALWAYS,     target: UA_FINISH};
      4'd10:   w = '{op: OP_HALF,   jc: JC_NONE,       target: UA_MUL};
      4'd11:   w = '{op: OP_FINISH, jc: JC_NONE,       target: UA_MUL};
      default: w = '{op: OP_FINISH, jc: JC_NONE,       target: UA_MUL};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> rtl/qkdv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module qkdv_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/qkdv_datapath.sv
// Datapath of the quaternion key decoder, driven one operation per cycle.
`default_nettype none

module qkdv_datapath (
  input  logic                        clk,
  input  qkdv_pkg::ctrl_t             ctrl,
  input  logic [15:0]                 word_a,
  input  logic [15:0]                 word_b,
  input  logic [15:0]                 word_c,
  input  logic [7:0]                  track,
  input  logic                        first_key,
  input  logic [qkdv_pkg::ROT_W-1:0]  prev_rot,
  output logic [qkdv_pkg::SLOT_W-1:0] slot,
  output logic                        ram_we,
  output logic [qkdv_pkg::ROT_W-1:0]  ram_wdata,
  output qkdv_pkg::flags_t            flags,
  output logic [2:0]                  status,
  output logic signed [15:0]          comp_0,
  output logic signed [15:0]          comp_1,
  output logic signed [15:0]          comp_2,
  output logic signed [15:0]          comp_3
);

  function automatic logic [15:0] abs16(input logic signed [15:0] x);
    logic signed [15:0] n;
    n = -x;
    return x[15] ? 16'(n) : 16'(x);
  endfunction

  // Key and working registers.
  logic [47:0]               pk;
  logic                      first_k;
  logic [1:0]                cnt;
  logic                      neg;
  logic [29:0]               prod;
  logic signed [15:0]        v;
  logic signed [15:0]        q [4];
  logic [30:0]               sum;
  logic [30:0]               sx;
  logic [31:0]               root;
  logic [30:0]               bitm;
  logic signed [15:0]        big;
  logic signed [31:0]        pd;
  logic signed [33:0]        acc;
  qkdv_pkg::status_t         st;

  logic [1:0]                largest;
  logic [14:0]               code;
  logic                      neg_c;
  logic [15:0]               two;
  logic [14:0]               mag_c;
  logic [29:0]               prod_c;
  logic [14:0]               quot_t;
  logic [15:0]               quot_s;
  logic [14:0]               quot;
  logic signed [15:0]        quot_sg;
  logic signed [15:0]        v_c;
  logic [1:0]                pos_c;
  logic signed [31:0]        sq;
  logic [31:0]               trial;
  logic                      take;
  logic [14:0]               r15;
  logic signed [15:0]        r_sg;
  logic signed [15:0]        big_c;
  logic [15:0]               big_lim;
  logic                      big_bad;
  logic                      sum_bad;
  logic signed [15:0]        p_sel;
  logic signed [15:0]        q_sel;
  logic signed [31:0]        pd_c;
  logic                      half_bad;
  logic                      st_ok;

  assign largest = pk[1:0];
  assign st_ok   = (st == qkdv_pkg::ST_OK);

  // Select the 15-bit code of the current small component.
  always_comb begin
    case (cnt)
      2'd0:    code = pk[17:3];
      2'd1:    code = pk[32:18];
      default: code = pk[47:33];
    endcase
  end

  // Decode: d = 2*code - 32767, magnitude scaled by 0.7071 and rounded.
  always_comb begin
    neg_c  = ~code[14];
    two    = {code, 1'b0};
    mag_c  = neg_c ? 15'(16'd32767 - two) : 15'(two - 16'd32767);
    prod_c = 30'(mag_c) * 30'(qkdv_pkg::DEC_SCALE) + 30'(qkdv_pkg::DEC_ROUND);
  end

  // Division by 32767 = 2^15 - 1: high part plus one correction step.
  always_comb begin
    quot_t  = prod[29:15];
    quot_s  = {1'b0, quot_t} + {1'b0, prod[14:0]};
    quot    = quot_t + {14'd0, (quot_s >= {1'b0, qkdv_pkg::DEC_DIV})};
    quot_sg = signed'({1'b0, quot});
    v_c     = neg ? -quot_sg : quot_sg;
    pos_c   = cnt + {1'b0, (cnt >= largest)};
  end

  // Square of the last decoded component.
  assign sq = 32'(v) * 32'(v);
  assign sum_bad = (sum > qkdv_pkg::SUM_LIMIT);

  // One step of the bit-pair square root.
  always_comb begin
    trial = root + {1'b0, bitm};
    take  = ({1'b0, sx} >= trial);
  end

  // Rebuilt largest component, saturated and signed.
  always_comb begin
    r15   = (root > 32'(qkdv_pkg::Q15_MAX)) ? qkdv_pkg::Q15_MAX : root[14:0];
    r_sg  = signed'({1'b0, r15});
    big_c = pk[2] ? -r_sg : r_sg;
  end

  // Largest-component check over all four components.
  always_comb begin
    big_lim = abs16(big) + qkdv_pkg::BIG_SLACK;
    big_bad = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (abs16(q[i]) > big_lim) begin
        big_bad = 1'b1;
      end
    end
  end

  // Dot-product term for the current component.
  always_comb begin
    case (cnt)
      2'd0:    p_sel = signed'(prev_rot[15:0]);
      2'd1:    p_sel = signed'(prev_rot[31:16]);
      2'd2:    p_sel = signed'(prev_rot[47:32]);
      default: p_sel = signed'(prev_rot[63:48]);
    endcase
    q_sel = q[cnt];
    pd_c  = 32'(q_sel) * 32'(p_sel);
  end

  // Half-float words with an all-ones exponent.
  assign half_bad = (pk[14:10] == qkdv_pkg::HALF_EXP_ONES) ||
                    (pk[30:26] == qkdv_pkg::HALF_EXP_ONES) ||
                    (pk[46:42] == qkdv_pkg::HALF_EXP_ONES);

  // Operation registers, one microcode operation per cycle.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      pk      <= {word_c, word_b, word_a};
      slot    <= track[qkdv_pkg::SLOT_W-1:0];
      first_k <= first_key;
      cnt     <= 2'd0;
      sum     <= '0;
      acc     <= '0;
      st      <= qkdv_pkg::ST_OK;
      for (int i = 0; i < 4; i++) begin
        q[i] <= '0;
      end
    end else begin
      unique case (ctrl.op)
        qkdv_pkg::OP_MUL: begin
          prod <= prod_c;
          neg  <= neg_c;
        end
        qkdv_pkg::OP_DIV: begin
          v        <= v_c;
          q[pos_c] <= v_c;
        end
        qkdv_pkg::OP_SQR: begin
          sum <= sum + 31'(sq[29:0]);
          cnt <= cnt + 2'd1;
        end
        qkdv_pkg::OP_CHKSUM: begin
          if (sum_bad) begin
            st <= qkdv_pkg::ST_SUM;
          end
          sx   <= qkdv_pkg::ONE_Q30 - sum;
          root <= '0;
          bitm <= qkdv_pkg::ONE_Q30;
        end
        qkdv_pkg::OP_SQRT: begin
          if (take) begin
            sx   <= sx - trial[30:0];
            root <= (root >> 1) + {1'b0, bitm};
          end else begin
            root <= root >> 1;
          end
          bitm <= bitm >> 2;
        end
        qkdv_pkg::OP_BIG: begin
          big        <= big_c;
          q[largest] <= big_c;
        end
        qkdv_pkg::OP_CHKBIG: begin
          if (big_bad) begin
            st <= qkdv_pkg::ST_BIG;
          end
          cnt <= 2'd0;
        end
        qkdv_pkg::OP_DOTMUL: begin
          pd <= pd_c;
        end
        qkdv_pkg::OP_DOTACC: begin
          acc <= acc + 34'(pd);
          cnt <= cnt + 2'd1;
        end
        qkdv_pkg::OP_CHKDOT: begin
          if (acc < qkdv_pkg::DOT_LIMIT) begin
            st <= qkdv_pkg::ST_FLIP;
          end
        end
        qkdv_pkg::OP_HALF: begin
          if (half_bad) begin
            st <= qkdv_pkg::ST_NAN;
          end
        end
        qkdv_pkg::OP_FINISH: begin
          status <= st;
          comp_0 <= st_ok ? q[0] : '0;
          comp_1 <= st_ok ? q[1] : '0;
          comp_2 <= st_ok ? q[2] : '0;
          comp_3 <= st_ok ? q[3] : '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Store the accepted rotation for the track at the end of the program.
  assign ram_we    = (ctrl.op == qkdv_pkg::OP_FINISH) && ctrl.rot && st_ok;
  assign ram_wdata = {q[3], q[2], q[1], q[0]};

  // Flags for the sequencer's jump conditions.
  always_comb begin
    flags.fail = ((ctrl.op == qkdv_pkg::OP_CHKSUM) && sum_bad) ||
                 ((ctrl.op == qkdv_pkg::OP_CHKBIG) && big_bad);
    flags.first     = first_k;
    flags.cnt       = cnt;
    flags.sqrt_last = bitm[0];
  end

endmodule

`default_nettype wire

>>> rtl/quaternion_key_decode_validate_unit.sv
// Top level of the quaternion key decoder: microcode sequencer and track store.
//
// Usage:
// The input channel (in_valid, in_stall) carries one compressed key per
// transfer: word_a, word_b, word_c, track and first_key. The output channel
// (out_valid, out_stall) carries one result per key: status and comp_0..3.
// cfg_wr_en with cfg_wr_data sets channel_is_rotation; write it only while
// the block is idle. Reset sets rotation mode and empties the pipeline; the
// per-track rotation store is not cleared and must be seeded by a first key.
// A microcode program steps a shared datapath, one operation per cycle while
// no held result stalls it: three decode passes of multiply, divide and square,
// 16 square-root steps, and four multiply-accumulate pairs for the hemisphere
// dot product. A first key, or a key that fails the sum or largest-component
// check, skips the dot product and finishes sooner; a failed sum check also
// skips the square root. A half-float key runs only the half-float check.
// The result sits in an output register; a new key is taken while it waits.
// While out_stall holds a result, a finished key waits in its last step and
// in_stall stays high until that result can move into the output register.
`default_nettype none
`include "quaternion_key_decode_validate_unit_defines.svh"

module quaternion_key_decode_validate_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        word_a,
  input  logic [15:0]        word_b,
  input  logic [15:0]        word_c,
  input  logic [7:0]         track,
  input  logic               first_key,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic signed [15:0] comp_0,
  output logic signed [15:0] comp_1,
  output logic signed [15:0] comp_2,
  output logic signed [15:0] comp_3
);

  logic                              channel_is_rotation;
  logic                              busy;
  logic                              busy_next;
  logic [qkdv_pkg::UPC_W-1:0]        upc;
  logic [qkdv_pkg::UPC_W-1:0]        upc_next;
  logic                              out_valid_next;
  qkdv_pkg::ucode_t                  cw;
  qkdv_pkg::ctrl_t                   ctrl;
  qkdv_pkg::flags_t                  flags;
  logic                              in_acc;
  logic                              hold;
  logic                              run;
  logic                              fin_exec;
  logic                              jump;
  logic [qkdv_pkg::SLOT_W-1:0]       slot;
  logic                              ram_we;
  logic [qkdv_pkg::ROT_W-1:0]        ram_wdata;
  logic [qkdv_pkg::ROT_W-1:0]        prev_rot;

  // Fetch the control word and decide whether this step may run.
  assign cw       = qkdv_pkg::ucode_rom(upc);
  assign in_stall = busy;
  assign in_acc   = in_valid && !busy;
  assign hold     = busy && (cw.op == qkdv_pkg::OP_FINISH) && out_valid && out_stall;
  assign run      = busy && !hold;
  assign fin_exec = run && (cw.op == qkdv_pkg::OP_FINISH);

  // Jump condition decode.
  always_comb begin
    unique case (cw.jc)
      qkdv_pkg::JC_NONE:       jump = 1'b0;
      qkdv_pkg::JC_ALWAYS:     jump = 1'b1;
      qkdv_pkg::JC_CNT2:       jump = (flags.cnt != 2'd2);
      qkdv_pkg::JC_CNT3:       jump = (flags.cnt != 2'd3);
      qkdv_pkg::JC_SQRT:       jump = !flags.sqrt_last;
      qkdv_pkg::JC_FAIL:       jump = flags.fail;
      qkdv_pkg::JC_FAIL_FIRST: jump = flags.fail || flags.first;
      default:                 jump = 1'b0;
    endcase
  end

  // Next step address, busy flag and output valid.
  always_comb begin
    upc_next       = upc;
    busy_next      = busy;
    out_valid_next = out_valid;
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
    if (in_acc) begin
      busy_next = 1'b1;
      upc_next  = channel_is_rotation ? qkdv_pkg::ENTRY_ROT : qkdv_pkg::ENTRY_HALF;
    end else if (fin_exec) begin
      busy_next      = 1'b0;
      out_valid_next = 1'b1;
    end else if (run) begin
      upc_next = jump ? cw.target : upc + 1'b1;
    end
  end

  // Sequencer state and the configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy                <= 1'b0;
      upc                 <= qkdv_pkg::ENTRY_ROT;
      out_valid           <= 1'b0;
      channel_is_rotation <= 1'b1;
    end else begin
      busy      <= busy_next;
      upc       <= upc_next;
      out_valid <= out_valid_next;
      if (cfg_wr_en) begin
        channel_is_rotation <= cfg_wr_data;
      end
    end
  end

  // Control word to the datapath; idle and held cycles issue no operation.
  always_comb begin
    ctrl.start = in_acc;
    ctrl.rot   = channel_is_rotation;
    ctrl.op    = run ? cw.op : qkdv_pkg::OP_NOP;
  end

  qkdv_datapath u_datapath (
    .clk       (clk),
    .ctrl      (ctrl),
    .word_a    (word_a),
    .word_b    (word_b),
    .word_c    (word_c),
    .track     (track),
    .first_key (first_key),
    .prev_rot  (prev_rot),
    .slot      (slot),
    .ram_we    (ram_we),
    .ram_wdata (ram_wdata),
    .flags     (flags),
    .status    (status),
    .comp_0    (comp_0),
    .comp_1    (comp_1),
    .comp_2    (comp_2),
    .comp_3    (comp_3)
  );

  // Last accepted rotation of each track.
  qkdv_ram #(
    .WIDTH (qkdv_pkg::ROT_W),
    .DEPTH (qkdv_pkg::TRACKS)
  ) u_last_rot (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (ram_wdata),
    .raddr (slot),
    .rdata (prev_rot)
  );

  // A finished program always leaves a result in the output register.
  `QKDV_ASSERT_NEXT(a_finish_valid, fin_exec, out_valid, "finished key left no result")

  // Rejected keys report all-zero components.
  `QKDV_ASSERT_NOW(a_reject_zero, out_valid && (status != qkdv_pkg::ST_OK), (comp_0 == 16'sd0) && (comp_1 == 16'sd0) && (comp_2 == 16'sd0) && (comp_3 == 16'sd0), "rejected key has nonzero components")

  // An accepted key starts at one of the two program entries.
  `QKDV_ASSERT_NEXT(a_entry, in_acc, busy && ((upc == qkdv_pkg::ENTRY_ROT) || (upc == qkdv_pkg::ENTRY_HALF)), "key did not start at a program entry")

  // A result held back by the receiver freezes the sequencer.
  `QKDV_ASSERT_NEXT(a_hold, hold, busy && $stable(upc), "sequencer moved while result was held")

endmodule

`default_nettype wire

>>> verif/tb_quaternion_key_decode_validate_unit.sv
// Self-checking testbench for the quaternion key decode and validate unit.
`default_nettype none

module tb_quaternion_key_decode_validate_unit;

  // Limits of the key checks, in the fixed-point formats of the datapath.
  localparam longint SUM_CEILING  = 805413742;
  localparam int     BIG_MARGIN   = 3;
  localparam longint DOT_FLOOR    = -214748;
  localparam int     Q15_TOP      = 32767;
  localparam logic [4:0] HALF_INF_EXP = 5'h1f;
  localparam logic [14:0] MID_CODE = 15'd16384;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 500;
  localparam int TAIL_CYCLES = 50;

  typedef struct packed {
    qkdv_pkg::status_t status;
    logic [3:0][15:0]  comp;
  } key_result_t;

  typedef struct {
    bit                rot;
    logic [47:0]       words;
    logic [7:0]        trk;
    bit                first;
    bit                typed;
    qkdv_pkg::status_t st;
  } key_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_wr_en;
  logic               cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic [15:0]        word_a;
  logic [15:0]        word_b;
  logic [15:0]        word_c;
  logic [7:0]         track;
  logic               first_key;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         status;
  logic signed [15:0] comp_0;
  logic signed [15:0] comp_1;
  logic signed [15:0] comp_2;
  logic signed [15:0] comp_3;

  // Predictor state: mode register and per-track last accepted rotation.
  bit                 channel_rot;
  logic signed [15:0] last_rot [qkdv_pkg::TRACKS][4];
  bit                 seeded [qkdv_pkg::TRACKS];

  key_result_t decoded_keys [$];
  key_row_t    directed_keys [$];
  int          mismatch_count;
  int          tx_idle_pct;
  bit          calm;
  bit          hold_req;

  quaternion_key_decode_validate_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .word_a      (word_a),
    .word_b      (word_b),
    .word_c      (word_c),
    .track       (track),
    .first_key   (first_key),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .comp_0      (comp_0),
    .comp_1      (comp_1),
    .comp_2      (comp_2),
    .comp_3      (comp_3)
  );

  always #4 clk = ~clk;

  // Maps a 15-bit code linearly onto -0.7071..+0.7071 in Q1.15.
  function automatic int small_component(input logic [14:0] code);
    int d;
    int m;
    int v;
    d = 2 * int'(code) - 32767;
    m = (d < 0) ? -d : d;
    v = (m * 23170 + 16383) / 32767;
    return (d < 0) ? -v : v;
  endfunction

  // Integer square root, built one result bit at a time from the top.
  function automatic int floor_sqrt(input longint x);
    int unsigned r;
    int unsigned t;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if (longint'(t) * longint'(t) <= x) r = t;
    end
    return int'(r);
  endfunction

  function automatic int mag(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [47:0] pack_key(input logic [1:0] lead, input bit neg,
                                           input logic [14:0] c0, c1, c2);
    return {c2, c1, c0, neg, lead};
  endfunction

  function automatic key_row_t row(input bit rot, input logic [47:0] words,
                                   input logic [7:0] trk, input bit first,
                                   input bit typed, input qkdv_pkg::status_t st);
    key_row_t k;
    k.rot = rot;
    k.words = words;
    k.trk = trk;
    k.first = first;
    k.typed = typed;
    k.st = st;
    return k;
  endfunction

  // Appends one row to the directed table.
  task automatic queue_row(input key_row_t k);
    directed_keys.insert(directed_keys.size(), k);
  endtask

  // Decodes one key, runs the checks in order and updates the track store.
  function automatic key_result_t decode_and_check(input logic [47:0] words,
                                                   input logic [7:0] trk,
                                                   input bit first);
    key_result_t       r;
    qkdv_pkg::status_t st;
    int                q [4];
    int                pos;
    int                root;
    int                big;
    int                slot;
    longint            sum;
    longint            dot;
    logic [1:0]        lead;
    r = '0;
    st = qkdv_pkg::ST_OK;
    q = '{0, 0, 0, 0};
    slot = int'(trk) % qkdv_pkg::TRACKS;
    if (!channel_rot) begin
      if (words[14:10] == HALF_INF_EXP || words[30:26] == HALF_INF_EXP ||
          words[46:42] == HALF_INF_EXP) st = qkdv_pkg::ST_NAN;
    end else begin
      lead = words[1:0];
      pos = 0;
      sum = 0;
      for (int n = 0; n < 3; n++) begin
        if (pos == int'(lead)) pos++;
        q[pos] = small_component(words[3 + 15 * n +: 15]);
        sum += longint'(q[pos]) * longint'(q[pos]);
        pos++;
      end
      if (sum > SUM_CEILING) begin
        st = qkdv_pkg::ST_SUM;
      end else begin
        root = floor_sqrt((longint'(1) << 30) - sum);
        if (root > Q15_TOP) root = Q15_TOP;
        big = words[2] ? -root : root;
        q[lead] = big;
        for (int n = 0; n < 4; n++) begin
          if (mag(q[n]) > mag(big) + BIG_MARGIN) st = qkdv_pkg::ST_BIG;
        end
        // The hemisphere test only applies to keys that are not marked as first keys.
        if (st == qkdv_pkg::ST_OK && !first) begin
          dot = 0;
          for (int n = 0; n < 4; n++) dot += longint'(q[n]) * longint'(last_rot[slot][n]);
          if (dot < DOT_FLOOR) st = qkdv_pkg::ST_FLIP;
        end
      end
      if (st == qkdv_pkg::ST_OK) begin
        for (int n = 0; n < 4; n++) last_rot[slot][n] = q[n][15:0];
        seeded[slot] = 1'b1;
      end
    end
    r.status = st;
    if (st == qkdv_pkg::ST_OK && channel_rot) begin
      for (int n = 0; n < 4; n++) r.comp[n] = q[n][15:0];
    end
    return r;
  endfunction

  // Offers one key and waits for its transfer, then records the prediction.
  task automatic send_key(input logic [47:0] words, input logic [7:0] trk,
                          input bit first, input bit typed, input qkdv_pkg::status_t st);
    key_result_t want;
    @(negedge clk);
    in_valid  <= 1'b1;
    word_a    <= words[15:0];
    word_b    <= words[31:16];
    word_c    <= words[47:32];
    track     <= trk;
    first_key <= first;
    do @(posedge clk); while (in_stall);
    want = decode_and_check(words, trk, first);
    if (typed) begin
      want.status = st;
      want.comp = '0;
    end
    decoded_keys.insert(decoded_keys.size(), want);
  endtask

  task automatic pause_tx(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic tx_idle();
    if (!calm && $urandom_range(0, 99) < tx_idle_pct) pause_tx($urandom_range(1, 13));
  endtask

  // Stops offering keys and waits until every predicted result has arrived.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (decoded_keys.size() != 0) @(posedge clk);
  endtask

  task automatic write_mode(input bit rot);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= rot;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    channel_rot = rot;
  endtask

  // Tracks come mostly from a small set so that the store gets reused.
  function automatic logic [7:0] pick_track();
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd2;
      3: return 8'd127;
      4: return 8'd128;
      default: return 8'd255;
    endcase
  endfunction

  function automatic bit pick_first(input logic [7:0] trk);
    return seeded[int'(trk) % qkdv_pkg::TRACKS] ? ($urandom_range(0, 4) == 0) : 1'b1;
  endfunction

  // Random rotation keys: mostly well-formed, some near the checks' edges.
  task automatic run_rotation(input int count, input bit pressure);
    int          kind;
    int          spread;
    logic [14:0] code [3];
    logic [47:0] words;
    logic [7:0]  trk;
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) tx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 :
                                     ($urandom_range(0, 1) == 0) ? 15 : 50;
      if (pressure && i == count / 3) hold_req = 1'b1;
      kind = $urandom_range(0, 9);
      spread = ($urandom_range(0, 2) == 0) ? 200 : ($urandom_range(0, 1) == 0) ? 3000 : 9000;
      for (int n = 0; n < 3; n++) begin
        if (kind < 6) code[n] = 15'(16384 - spread + int'($urandom_range(0, 2 * spread)));
        else if (kind < 8) code[n] = 15'($urandom_range(0, 32767));
        else code[n] = 15'(27965 + int'($urandom_range(0, 6)));
      end
      words = pack_key(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       code[0], code[1], code[2]);
      if (kind == 9) words = {16'($urandom), 16'($urandom), 16'($urandom)};
      trk = pick_track();
      send_key(words, trk, pick_first(trk), 1'b0, qkdv_pkg::ST_OK);
      tx_idle();
    end
  endtask

  // Random half-float keys, with the all-ones exponent forced now and then.
  task automatic run_half(input int count);
    logic [15:0] w [3];
    logic [7:0]  trk;
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) tx_idle_pct = ($urandom_range(0, 1) == 0) ? 0 : 30;
      for (int n = 0; n < 3; n++) begin
        w[n] = 16'($urandom);
        if ($urandom_range(0, 3) == 0) w[n][14:10] = HALF_INF_EXP;
      end
      trk = pick_track();
      send_key({w[2], w[1], w[0]}, trk, pick_first(trk), 1'b0, qkdv_pkg::ST_OK);
      tx_idle();
    end
  endtask

  // Receiver pacing: random stall bursts, one long hold-off on request.
  initial begin : rx_pacing
    int run;
    bit hold_on;
    out_stall = 1'b0;
    forever begin
      if (hold_req) begin
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
        hold_req = 1'b0;
      end else if (calm) begin
        @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        hold_on = ($urandom_range(0, 2) == 0);
        run = hold_on ? $urandom_range(1, 13) : $urandom_range(1, 30);
        repeat (run) begin
          @(negedge clk);
          out_stall <= hold_on;
        end
      end
    end
  end

  // Each result transfer is checked against the oldest prediction.
  always @(posedge clk) begin : check_results
    key_result_t got;
    key_result_t want;
    if (!rst && out_valid && !out_stall) begin
      got.status = qkdv_pkg::status_t'(status);
      got.comp = {comp_3, comp_2, comp_1, comp_0};
      if (decoded_keys.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status %0d comps %0d %0d %0d %0d", status,
                   comp_0, comp_1, comp_2, comp_3);
      end else begin
        want = decoded_keys.pop_front();
        if (got.status !== want.status || got.comp[0] !== want.comp[0] ||
            got.comp[1] !== want.comp[1] || got.comp[2] !== want.comp[2] ||
            got.comp[3] !== want.comp[3]) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected status %0d comps %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                     want.status, $signed(want.comp[0]), $signed(want.comp[1]),
                     $signed(want.comp[2]), $signed(want.comp[3]),
                     status, comp_0, comp_1, comp_2, comp_3);
        end
      end
    end
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    key_row_t k;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    in_valid    = 1'b0;
    word_a      = '0;
    word_b      = '0;
    word_c      = '0;
    track       = '0;
    first_key   = 1'b0;
    channel_rot = 1'b1;
    calm        = 1'b0;
    hold_req    = 1'b0;
    tx_idle_pct = 20;
    mismatch_count = 0;
    for (int t = 0; t < qkdv_pkg::TRACKS; t++) begin
      seeded[t] = 1'b0;
      for (int n = 0; n < 4; n++) last_rot[t][n] = '0;
    end

    // Directed keys: extremes, each largest index and sign, every status.
    queue_row(row(1, pack_key(0, 0, MID_CODE, MID_CODE, MID_CODE), 0, 1, 0, qkdv_pkg::ST_OK));
    queue_row(row(1, pack_key(0, 1, MID_CODE, MID_CODE, MID_CODE), 0, 0, 1,
                  qkdv_pkg::ST_FLIP));
    queue_row(row(1, pack_key(0, 1, MID_CODE, MID_CODE, MID_CODE), 0, 1, 0, qkdv_pkg::ST_OK));
    queue_row(row(1, pack_key(0, 1, 15'd16000, 15'd16900, 15'd16383), 0, 0, 0,
                  qkdv_pkg::ST_OK));
    queue_row(row(1, {3{16'hffff}}, 255, 1, 1, qkdv_pkg::ST_SUM));
    queue_row(row(1, {3{16'h0000}}, 0, 1, 1, qkdv_pkg::ST_SUM));
    queue_row(row(1, pack_key(1, 0, MID_CODE, MID_CODE, MID_CODE), 255, 1, 0,
                  qkdv_pkg::ST_OK));
    queue_row(row(1, pack_key(2, 1, MID_CODE, MID_CODE, MID_CODE), 255, 0, 0,
                  qkdv_pkg::ST_OK));
    queue_row(row(1, pack_key(3, 0, MID_CODE, MID_CODE, MID_CODE), 128, 1, 0,
                  qkdv_pkg::ST_OK));
    queue_row(row(1, pack_key(3, 1, MID_CODE, MID_CODE, MID_CODE), 128, 0, 1,
                  qkdv_pkg::ST_FLIP));
    queue_row(row(1, pack_key(0, 0, 15'd30286, 15'd30286, MID_CODE), 1, 1, 1,
                  qkdv_pkg::ST_BIG));
    queue_row(row(1, pack_key(0, 0, 15'd30286, 15'd30286, 15'd30286), 1, 1, 1,
                  qkdv_pkg::ST_SUM));
    queue_row(row(1, pack_key(2, 0, 15'd30286, 15'd30286, 15'd20402), 1, 1, 0,
                  qkdv_pkg::ST_OK));
    // Just inside and just past the largest-component margin.
    queue_row(row(1, pack_key(0, 0, 15'd27968, 15'd27968, 15'd27968), 2, 1, 0,
                  qkdv_pkg::ST_OK));
    queue_row(row(1, pack_key(0, 0, 15'd27969, 15'd27969, 15'd27969), 2, 1, 0,
                  qkdv_pkg::ST_OK));
    queue_row(row(1, pack_key(1, 1, MID_CODE, MID_CODE, MID_CODE), 255, 1, 0,
                  qkdv_pkg::ST_OK));
    // Half-float keys.
    queue_row(row(0, {16'h0000, 16'h0000, 16'h7c00}, 3, 1, 1, qkdv_pkg::ST_NAN));
    queue_row(row(0, {3{16'h7bff}}, 0, 0, 1, qkdv_pkg::ST_OK));
    queue_row(row(0, {3{16'hffff}}, 255, 1, 1, qkdv_pkg::ST_NAN));
    queue_row(row(0, {3{16'h0000}}, 255, 0, 1, qkdv_pkg::ST_OK));
    queue_row(row(0, {16'hfc00, 16'h0000, 16'h0000}, 4, 1, 1, qkdv_pkg::ST_NAN));
    queue_row(row(0, {16'h0000, 16'h7fff, 16'h0000}, 0, 1, 1, qkdv_pkg::ST_NAN));
    queue_row(row(0, {16'hfbff, 16'h83ff, 16'h8000}, 200, 1, 1, qkdv_pkg::ST_OK));
    // The store must survive a trip through half-float mode.
    queue_row(row(1, pack_key(2, 0, MID_CODE, MID_CODE, MID_CODE), 0, 0, 0, qkdv_pkg::ST_OK));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_keys[i]) begin
      k = directed_keys[i];
      if (k.rot != channel_rot) write_mode(k.rot);
      send_key(k.words, k.trk, k.first, k.typed, k.st);
      tx_idle();
    end

    // Random phases across both modes; the last one runs without idling.
    write_mode(1'b1);
    run_rotation(500, 1'b1);
    write_mode(1'b0);
    run_half(250);
    write_mode(1'b1);
    run_rotation(500, 1'b0);
    write_mode(1'b0);
    run_half(150);
    write_mode(1'b1);
    calm = 1'b1;
    run_rotation(250, 1'b0);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
